// ===== hw/rtl/mvic_pkg.sv =====
package mvic_pkg;

  localparam int unsigned CntBits    = 10;   // line counter width
  localparam int unsigned CfgBits    = 10;   // line_compare width
  localparam int unsigned CmpW       = (CntBits > CfgBits) ? CntBits : CfgBits;
  localparam int unsigned NumSources = 30;

  localparam logic [15:0] MaskReset  = 16'hBFFF;

  // source numbers with special handling
  localparam logic [4:0] SrcVblankOut = 5'd1;
  localparam logic [4:0] SrcHblank    = 5'd2;
  localparam logic [4:0] SrcTimer0    = 5'd3;

  typedef enum logic [1:0] {
    ReqRaise  = 2'd0,
    ReqMask   = 2'd1,
    ReqStatus = 2'd2
  } req_e;

  typedef struct packed {
    logic        irq_valid;
    logic [3:0]  irq_level;
    logic [6:0]  irq_vector;
    logic [15:0] status_now;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0]        status;
    logic [15:0]        mask;
    logic [CntBits-1:0] line_cnt;
  } state_t;

  function automatic logic [6:0] src_vector(input logic [4:0] src);
    logic [6:0] v;
    if (src < 5'd14) begin
      v = 7'h40 + {2'b00, src};
    end else begin
      v = 7'h50 + {2'b00, src - 5'd14};
    end
    return v;
  endfunction

  function automatic logic [3:0] src_level(input logic [4:0] src);
    logic [3:0] l;
    case (src) inside
      5'd0:          l = 4'hF;
      5'd1:          l = 4'hE;
      5'd2:          l = 4'hD;
      5'd3:          l = 4'hC;
      5'd4:          l = 4'hB;
      5'd5:          l = 4'hA;
      5'd6:          l = 4'h9;
      5'd7, 5'd8:    l = 4'h8;
      5'd9, 5'd10:   l = 4'h6;
      5'd11:         l = 4'h5;
      5'd12:         l = 4'h3;
      5'd13:         l = 4'h2;
      [5'd14:5'd17]: l = 4'h7;
      [5'd18:5'd21]: l = 4'h4;
      [5'd22:5'd29]: l = 4'h1;
      default:       l = 4'h0;
    endcase
    return l;
  endfunction

  // internal sources own one bit each; all external ones share bit 15
  function automatic logic [15:0] src_status(input logic [4:0] src);
    logic [15:0] s;
    if (src < 5'd14) begin
      s = 16'h0001 << src;
    end else begin
      s = 16'h8000;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/mvic_eval.sv =====
// One request against the current state: up to two results and the next state.
module mvic_eval (
  input  logic [1:0]                  req_type_i,
  input  logic [4:0]                  source_i,
  input  logic [15:0]                 data_i,
  input  logic [mvic_pkg::CfgBits-1:0] line_compare_i,
  input  mvic_pkg::state_t            state_i,
  output mvic_pkg::state_t            state_o,
  output mvic_pkg::result_t           res0_o,
  output mvic_pkg::result_t           res1_o,
  output logic                        two_o
);

  logic                         src_ok;
  logic [15:0]                  bit0;
  logic [15:0]                  status1;
  logic [15:0]                  status2;
  logic                         deliver0;
  logic                         deliver1;
  logic [mvic_pkg::CntBits-1:0] cnt_inc;
  logic                         match;

  assign src_ok   = source_i inside {[5'd0:5'd29]};
  assign bit0     = mvic_pkg::src_status(source_i);
  assign status1  = state_i.status | bit0;
  assign status2  = status1 | mvic_pkg::src_status(mvic_pkg::SrcTimer0);
  assign deliver0 = (state_i.mask & bit0) == 16'h0000;
  assign deliver1 = (state_i.mask & mvic_pkg::src_status(mvic_pkg::SrcTimer0)) == 16'h0000;
  assign cnt_inc  = state_i.line_cnt + 1'b1;
  assign match    = mvic_pkg::CmpW'(cnt_inc) == mvic_pkg::CmpW'(line_compare_i);

  always_comb begin
    state_o = state_i;
    res0_o  = '0;
    res1_o  = '0;
    two_o   = 1'b0;
    res0_o.status_now = state_i.status;
    res0_o.last       = 1'b1;
    case (mvic_pkg::req_e'(req_type_i))
      mvic_pkg::ReqMask: begin
        state_o.mask = data_i;
      end
      mvic_pkg::ReqStatus: begin
        state_o.status    = state_i.status & data_i;
        res0_o.status_now = state_i.status & data_i;
      end
      mvic_pkg::ReqRaise: begin
        if (src_ok) begin
          state_o.status    = status1;
          res0_o.irq_valid  = deliver0;
          res0_o.irq_level  = deliver0 ? mvic_pkg::src_level(source_i) : 4'h0;
          res0_o.irq_vector = deliver0 ? mvic_pkg::src_vector(source_i) : 7'h00;
          res0_o.status_now = status1;
          if (source_i == mvic_pkg::SrcHblank) begin
            state_o.line_cnt = cnt_inc;
            if (match) begin
              // compare hit: timer 0 follows the hblank result
              two_o             = 1'b1;
              res0_o.last       = 1'b0;
              state_o.status    = status2;
              res1_o.irq_valid  = deliver1;
              res1_o.irq_level  = deliver1 ? mvic_pkg::src_level(mvic_pkg::SrcTimer0) : 4'h0;
              res1_o.irq_vector = deliver1 ? mvic_pkg::src_vector(mvic_pkg::SrcTimer0) : 7'h00;
              res1_o.status_now = status2;
              res1_o.last       = 1'b1;
            end
          end else if (source_i == mvic_pkg::SrcVblankOut) begin
            state_o.line_cnt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/masked_vectored_interrupt_controller.sv =====
// Masked vectored interrupt controller. Each request on the slave stream is a
// source raise (tuser = 0), a mask write (1) or an AND-write of the pending
// status (2). A raise of a source 0..29 sets the source's status bit and
// delivers an interrupt with the source's fixed level and vector only when
// its mask bit is clear. Horizontal blank also bumps a line counter (wraps at
// 2^CntBits); when the new count equals line_compare, a second result
// follows for timer 0. Vertical blank out clears the counter. Every request
// yields one result, or two on a compare hit, the final one flagged by tlast.
// Timing: a request is registered, evaluated once the output buffer has room
// and its results land in a two-entry output buffer. Requests flow at one per
// cycle while the output is ready; a compare hit holds the evaluation stage
// while its second result drains. Mask and reset value of mask: 0xBFFF.
// line_compare is written on the cfg channel, which is always ready and
// should only be used idle.
module masked_vectored_interrupt_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [4:0] source, [20:5] data, [23:21] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [3:0] irq_level, [10:4] irq_vector,
                                      // [26:11] status_now, [31:27] zero
  output logic        m_axis_tuser,   // [0] irq_valid
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [mvic_pkg::CfgBits-1:0] cfg_data_i
);

  // line compare register
  logic [mvic_pkg::CfgBits-1:0] line_compare_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_compare_q <= '0;
    end else if (cfg_valid_i) begin
      line_compare_q <= cfg_data_i;
    end
  end

  // input register
  logic        in_valid_q;
  logic [1:0]  req_q;
  logic [4:0]  src_q;
  logic [15:0] data_q;

  // output buffer: head entry goes out first
  logic [1:0]          out_cnt_q, out_cnt_d;
  mvic_pkg::result_t   head_q, head_d;
  mvic_pkg::result_t   tail_q, tail_d;

  mvic_pkg::state_t    state_q, state_d;
  mvic_pkg::result_t   res0, res1;
  logic                two;

  logic pop;
  logic fire;
  logic room;

  assign pop  = m_axis_tvalid && m_axis_tready;
  // evaluate only when both buffer entries are free after this cycle
  assign room = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && pop);
  assign fire = in_valid_q && room;

  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q  <= s_axis_tuser;
      src_q  <= s_axis_tdata[4:0];
      data_q <= s_axis_tdata[20:5];
    end
  end

  mvic_eval u_eval (
    .req_type_i     (req_q),
    .source_i       (src_q),
    .data_i         (data_q),
    .line_compare_i (line_compare_q),
    .state_i        (state_q),
    .state_o        (state_d),
    .res0_o         (res0),
    .res1_o         (res1),
    .two_o          (two)
  );

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.status   <= 16'h0000;
      state_q.mask     <= mvic_pkg::MaskReset;
      state_q.line_cnt <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // buffer update
  always_comb begin
    out_cnt_d = out_cnt_q;
    head_d    = head_q;
    tail_d    = tail_q;
    if (fire) begin
      head_d    = res0;
      tail_d    = res1;
      out_cnt_d = two ? 2'd2 : 2'd1;
    end else if (pop) begin
      head_d    = tail_q;
      out_cnt_d = out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= 2'd0;
    end else begin
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign m_axis_tvalid = out_cnt_q != 2'd0;
  assign m_axis_tdata  = {5'b00000, head_q.status_now, head_q.irq_vector, head_q.irq_level};
  assign m_axis_tuser  = head_q.irq_valid;
  assign m_axis_tlast  = head_q.last;

`ifndef ASSERT_OFF
  a_two_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && two |=> out_cnt_q == 2'd2)
    else $error("compare hit did not fill both buffer entries");

  a_head_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_cnt_q != 2'd0) && !head_q.last |-> out_cnt_q == 2'd2)
    else $error("non-final result without its follower");

  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && in_valid_q |-> fire)
    else $error("request accepted over a held one");

  a_vblank_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (req_q == mvic_pkg::ReqRaise) && (src_q == mvic_pkg::SrcVblankOut)
      |=> state_q.line_cnt == '0)
    else $error("vblank out did not clear line counter");
`endif

endmodule
